@@ sv/nspe_pkg.sv @@
package nspe_pkg;

   typedef enum logic [2:0] {
      REG_HALF_LENGTH = 3'd0,
      REG_RECIP_HALF_LENGTH = 3'd1,
      REG_BASE_TERM = 3'd2,
      REG_NECK_COEFF = 3'd3,
      REG_ASYM_COEFF = 3'd4
   } csr_index_type;

   localparam int CSR_INDEX_BITS = 3;
   localparam int EXP_TERMS = 24;
   localparam int EXP_LAT = 4 * EXP_TERMS + 2;
   localparam logic [63:0] LN2_Q56 = 64'h00B1_7217_F7D1_CF7A;
   localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;

endpackage

@@ sv/nuclear_shape_profile_eval_core.sv @@
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_position
// rsp      out        rsp_valid/rsp_ready  rsp_radius_squared, rsp_radius
// csr      in         csr_write_enable     csr_index, csr_wdata
//
// One request per cycle sustained while responses are taken; the pipeline depth is set
// by the 24-term exponential series (four stages per term) and the bit-per-stage
// square root. Reset (synchronous) restores the registers and empties the pipeline.
// A stalled response freezes the whole pipeline.
module nuclear_shape_profile_eval_core
   import nspe_pkg::*;
#(
   parameter int WORD_BITS = 24,
   parameter int FRAC_BITS = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [WORD_BITS-1:0] req_position,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [WORD_BITS-2:0]      rsp_radius_squared,
   output logic [WORD_BITS-2:0]      rsp_radius,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]      csr_wdata
);

   localparam int W = WORD_BITS;
   localparam int RB = (W + FRAC_BITS) / 2;
   localparam int DLY = EXP_LAT - 2;
   localparam int LAT = 6 + DLY + RB;
   localparam logic [W-1:0] ONE_W = W'(1) << FRAC_BITS;

   typedef struct packed {
      logic signed [W-1:0] d;
      logic signed [W-1:0] lin;
      logic signed [W-1:0] tpos;
   } row_type;

   logic [W-2:0] half_length_ff, recip_ff;
   logic signed [W-1:0] base_ff, neck_ff, asym_ff;
   logic [LAT:1] vld_ff;
   logic en;

   logic signed [W-1:0] z_c, c_s, rc_s;
   logic signed [W-1:0] zz_in, zc_in, cc_in, nc_in;
   logic signed [W-1:0] zz_ff, zc_ff, cc_ff, nc_ff;
   logic signed [W-1:0] d2_in, azc_in, zc2_in, arg_in;
   logic signed [W-1:0] d2_ff, azc_ff, zc2_ff, arg_ff;
   logic signed [W-1:0] lin3_in, nzc2_in;
   logic signed [W-1:0] d3_ff, lin3_ff, nzc2_ff;
   row_type row_in;
   row_type row_ff [0:DLY];
   logic [W-1:0] e_exp;
   logic signed [W-1:0] le_in, le_ff;
   row_type row53_ff;
   logic signed [W-1:0] rn_c, rp_c, res_c;
   logic [W-2:0] res_in, res_ff;

   function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] v);
      logic signed [W:0] hi, lo;
      hi = (W+1)'((W+1)'(1) << (W - 1)) - (W+1)'(1);
      lo = ~hi;
      if (v > hi) begin
         return hi[W-1:0];
      end else if (v < lo) begin
         return lo[W-1:0];
      end
      return v[W-1:0];
   endfunction

   assign en = !vld_ff[LAT] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LAT];

   assign z_c = req_position;
   assign c_s = $signed({1'b0, half_length_ff});
   assign rc_s = $signed({1'b0, recip_ff});

   nspe_fxmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_zz (.a(z_c), .b(z_c), .p(zz_in));
   nspe_fxmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_zc (.a(z_c), .b(rc_s), .p(zc_in));
   nspe_fxmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_cc (.a(c_s), .b(c_s), .p(cc_in));
   nspe_fxmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_nc (.a(neck_ff), .b(c_s), .p(nc_in));

   assign d2_in = sat_sum({cc_ff[W-1], cc_ff} - {zz_ff[W-1], zz_ff});
   nspe_fxmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_azc
      (.a(asym_ff), .b(zc_ff), .p(azc_in));
   nspe_fxmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_zc2
      (.a(zc_ff), .b(zc_ff), .p(zc2_in));
   nspe_fxmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_arg
      (.a(nc_ff), .b(zz_ff), .p(arg_in));

   assign lin3_in = sat_sum({base_ff[W-1], base_ff} + {azc_ff[W-1], azc_ff});
   nspe_fxmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_nzc2
      (.a(neck_ff), .b(zc2_ff), .p(nzc2_in));

   always_comb begin
      row_in.d = d3_ff;
      row_in.lin = lin3_ff;
      row_in.tpos = sat_sum({lin3_ff[W-1], lin3_ff} + {nzc2_ff[W-1], nzc2_ff});
   end

   nspe_exp #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_exp (
      .clock(clock),
      .en(en),
      .arg(arg_ff),
      .e(e_exp)
   );

   nspe_fxmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_le
      (.a(row_ff[DLY].lin), .b($signed(e_exp)), .p(le_in));
   nspe_fxmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_rn
      (.a(row53_ff.d), .b(le_ff), .p(rn_c));
   nspe_fxmul #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_rp
      (.a(row53_ff.d), .b(row53_ff.tpos), .p(rp_c));

   always_comb begin
      res_c = neck_ff[W-1] ? rn_c : rp_c;
      res_in = res_c[W-1] ? '0 : res_c[W-2:0];
   end

   nspe_sqrt #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock(clock),
      .en(en),
      .value(res_ff),
      .root(rsp_radius),
      .value_out(rsp_radius_squared)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         half_length_ff <= ONE_W[W-2:0];
         recip_ff <= ONE_W[W-2:0];
         base_ff <= ONE_W;
         neck_ff <= '0;
         asym_ff <= '0;
         vld_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               REG_HALF_LENGTH: half_length_ff <= csr_wdata[W-2:0];
               REG_RECIP_HALF_LENGTH: recip_ff <= csr_wdata[W-2:0];
               REG_BASE_TERM: base_ff <= csr_wdata;
               REG_NECK_COEFF: neck_ff <= csr_wdata;
               REG_ASYM_COEFF: asym_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (en) begin
            vld_ff <= {vld_ff[LAT-1:1], req_valid};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zz_ff <= zz_in;
         zc_ff <= zc_in;
         cc_ff <= cc_in;
         nc_ff <= nc_in;
         d2_ff <= d2_in;
         azc_ff <= azc_in;
         zc2_ff <= zc2_in;
         arg_ff <= arg_in;
         d3_ff <= d2_ff;
         lin3_ff <= lin3_in;
         nzc2_ff <= nzc2_in;
         row_ff[0] <= row_in;
         for (int i = 1; i <= DLY; i++) begin
            row_ff[i] <= row_ff[i-1];
         end
         row53_ff <= row_ff[DLY];
         le_ff <= le_in;
         res_ff <= res_in;
      end
   end

endmodule

@@ sv/nspe_fxmul.sv @@
module nspe_fxmul #(
   parameter int WORD_BITS = 24,
   parameter int FRAC_BITS = 20
) (
   input  logic signed [WORD_BITS-1:0] a,
   input  logic signed [WORD_BITS-1:0] b,
   output logic signed [WORD_BITS-1:0] p
);

   localparam int PW = 2 * WORD_BITS;
   localparam logic [PW-1:0] WMAX_P = (PW'(1) << (WORD_BITS - 1)) - PW'(1);
   localparam logic [WORD_BITS-1:0] WMAX_W = WMAX_P[WORD_BITS-1:0];
   localparam logic [WORD_BITS-1:0] WMIN_W = ~WMAX_W;

   logic [WORD_BITS-1:0] au, bu, mag_a, mag_b;
   logic [PW-1:0] prod, rnd;
   logic neg;

   always_comb begin
      au = a;
      bu = b;
      mag_a = au[WORD_BITS-1] ? (~au + 1'b1) : au;
      mag_b = bu[WORD_BITS-1] ? (~bu + 1'b1) : bu;
      neg = au[WORD_BITS-1] ^ bu[WORD_BITS-1];
      prod = PW'(mag_a) * PW'(mag_b);
      rnd = (prod + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      if (neg) begin
         if (rnd > WMAX_P + PW'(1)) begin
            p = WMIN_W;
         end else begin
            p = ~rnd[WORD_BITS-1:0] + 1'b1;
         end
      end else begin
         if (rnd > WMAX_P) begin
            p = WMAX_W;
         end else begin
            p = rnd[WORD_BITS-1:0];
         end
      end
   end

endmodule

@@ sv/nspe_exp.sv @@
module nspe_exp
   import nspe_pkg::*;
#(
   parameter int WORD_BITS = 24,
   parameter int FRAC_BITS = 20
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic signed [WORD_BITS-1:0] arg,
   output logic [WORD_BITS-1:0]        e
);

   localparam int T = EXP_TERMS;
   localparam int CS = 4 * T;

   typedef struct packed {
      logic [63:0] r;
      logic [6:0]  k;
      logic        zero;
   } carry_type;

   typedef struct packed {
      logic [63:0] p00;
      logic [63:0] p01;
      logic [63:0] p10;
      logic [63:0] p11;
   } prod_type;

   typedef struct packed {
      logic [63:0] q00;
      logic [63:0] q01;
      logic [63:0] q10;
      logic [63:0] q11;
      logic [63:0] x;
   } quot_type;

   carry_type car_ff [0:CS];
   carry_type car_in [0:CS];
   logic [63:0] s_ff [0:T];
   logic [63:0] s_in [0:T];
   prod_type pp_ff [0:T-1];
   prod_type pp_in [0:T-1];
   logic [63:0] x_ff [0:T-1];
   logic [63:0] x_in [0:T-1];
   quot_type qp_ff [0:T-1];
   quot_type qp_in [0:T-1];
   logic [WORD_BITS-1:0] e_ff, e_in;

   always_comb begin
      logic [WORD_BITS-1:0] au, mag;
      logic [63:0] t64, rem;
      logic [6:0] kq;
      au = arg;
      mag = au[WORD_BITS-1] ? (~au + 1'b1) : '0;
      t64 = 64'(mag);
      rem = t64 << (56 - FRAC_BITS);
      kq = '0;
      for (int j = 6; j >= 0; j--) begin
         if (rem >= (LN2_Q56 << j)) begin
            rem = rem - (LN2_Q56 << j);
            kq[j] = 1'b1;
         end
      end
      car_in[0].zero = t64 >= (64'd64 << FRAC_BITS);
      car_in[0].k = kq;
      car_in[0].r = rem << 6;
      s_in[0] = Q62_ONE;
   end

   for (genvar g = 0; g < T; g++) begin : g_term
      // divide by the term index through a reciprocal multiply
      localparam int DIV = T - g;
      localparam int DSH = $clog2(DIV);
      localparam logic [127:0] MAGIC =
         ((128'd1 << (64 + DSH)) + 128'(DIV) - 128'd1) / 128'(DIV);

      always_comb begin
         pp_in[g].p00 = 64'(car_ff[4*g].r[31:0]) * 64'(s_ff[g][31:0]);
         pp_in[g].p01 = 64'(car_ff[4*g].r[31:0]) * 64'(s_ff[g][63:32]);
         pp_in[g].p10 = 64'(car_ff[4*g].r[63:32]) * 64'(s_ff[g][31:0]);
         pp_in[g].p11 = 64'(car_ff[4*g].r[63:32]) * 64'(s_ff[g][63:32]);
         car_in[4*g+1] = car_ff[4*g];
      end

      always_comb begin
         logic [127:0] sum;
         sum = 128'(pp_ff[g].p00) + (128'(pp_ff[g].p01) << 32)
             + (128'(pp_ff[g].p10) << 32) + (128'(pp_ff[g].p11) << 64)
             + (128'd1 << 61);
         x_in[g] = sum[125:62];
         car_in[4*g+2] = car_ff[4*g+1];
      end

      always_comb begin
         qp_in[g].q00 = 64'(x_ff[g][31:0]) * 64'(MAGIC[31:0]);
         qp_in[g].q01 = 64'(x_ff[g][31:0]) * 64'(MAGIC[63:32]);
         qp_in[g].q10 = 64'(x_ff[g][63:32]) * 64'(MAGIC[31:0]);
         qp_in[g].q11 = 64'(x_ff[g][63:32]) * 64'(MAGIC[63:32]);
         qp_in[g].x = x_ff[g];
         car_in[4*g+3] = car_ff[4*g+2];
      end

      always_comb begin
         logic [128:0] sum;
         sum = 129'(qp_ff[g].q00) + (129'(qp_ff[g].q01) << 32)
             + (129'(qp_ff[g].q10) << 32) + (129'(qp_ff[g].q11) << 64)
             + (MAGIC[64] ? (129'(qp_ff[g].x) << 64) : 129'd0);
         s_in[g+1] = Q62_ONE - 64'(sum >> (64 + DSH));
         car_in[4*g+4] = car_ff[4*g+3];
      end
   end

   always_comb begin
      logic [7:0] sh;
      sh = 8'(62 - FRAC_BITS) + 8'(car_ff[CS].k);
      if (car_ff[CS].zero || sh > 8'd63) begin
         e_in = '0;
      end else begin
         e_in = WORD_BITS'((s_ff[T] + (64'd1 << (sh - 8'd1))) >> sh);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= CS; i++) begin
            car_ff[i] <= car_in[i];
         end
         for (int i = 0; i <= T; i++) begin
            s_ff[i] <= s_in[i];
         end
         for (int i = 0; i < T; i++) begin
            pp_ff[i] <= pp_in[i];
            x_ff[i] <= x_in[i];
            qp_ff[i] <= qp_in[i];
         end
         e_ff <= e_in;
      end
   end

   assign e = e_ff;

endmodule

@@ sv/nspe_sqrt.sv @@
module nspe_sqrt #(
   parameter int WORD_BITS = 24,
   parameter int FRAC_BITS = 20
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [WORD_BITS-2:0] value,
   output logic [WORD_BITS-2:0] root,
   output logic [WORD_BITS-2:0] value_out
);

   localparam int VB = WORD_BITS - 1 + FRAC_BITS;
   localparam int RB = (VB + 1) / 2;
   localparam int XW = 2 * RB + 2;

   logic [XW-1:0] rem_ff [1:RB];
   logic [XW-1:0] rem_in [0:RB-1];
   logic [RB-1:0] y_ff [1:RB];
   logic [RB-1:0] y_in [0:RB-1];
   logic [WORD_BITS-2:0] val_ff [1:RB];

   always_comb begin
      logic [XW-1:0] rem, trial;
      logic [RB-1:0] y;
      for (int j = 0; j < RB; j++) begin
         if (j == 0) begin
            rem = XW'(value) << FRAC_BITS;
            y = '0;
         end else begin
            rem = rem_ff[j];
            y = y_ff[j];
         end
         trial = (XW'(y) << (RB - j)) | (XW'(1) << (2 * (RB - 1 - j)));
         if (rem >= trial) begin
            rem = rem - trial;
            y[RB-1-j] = 1'b1;
         end
         rem_in[j] = rem;
         y_in[j] = y;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 1; j <= RB; j++) begin
            rem_ff[j] <= rem_in[j-1];
            y_ff[j] <= y_in[j-1];
         end
         val_ff[1] <= value;
         for (int j = 2; j <= RB; j++) begin
            val_ff[j] <= val_ff[j-1];
         end
      end
   end

   assign root = (WORD_BITS-1)'(y_ff[RB]);
   assign value_out = val_ff[RB];

endmodule
